// ===== sv/aabbcr_pkg.sv =====
package aabbcr_pkg;

   // field widths fixed by the interface
   localparam int POS_W   = 24;
   localparam int HALF_W  = 22;
   localparam int VEL_W   = 16;
   localparam int LAYER_W = 16;
   localparam int SHIFT_W = 25;
   localparam int STEP_W  = 8;

   // first box center plus shift
   localparam int CTR_W   = 26;
   // box edges and overlap extents
   localparam int COORD_W = 28;
   // shift plus extent before saturation
   localparam int SUM_W   = 29;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_X,
      ST_EVAL_Y,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   // one axis of the shared overlap unit
   typedef struct packed {
      logic                      overlap;
      logic signed [COORD_W-1:0] extent;
   } axis_result_type;

endpackage

// ===== sv/aabbcr_axis_unit.sv =====
module aabbcr_axis_unit (
   input  logic signed [aabbcr_pkg::CTR_W-1:0]  first_center,
   input  logic        [aabbcr_pkg::HALF_W-1:0] first_half,
   input  logic signed [aabbcr_pkg::POS_W-1:0]  second_center,
   input  logic        [aabbcr_pkg::HALF_W-1:0] second_half,
   output aabbcr_pkg::axis_result_type          result
);

   localparam int CW = aabbcr_pkg::COORD_W;

   logic signed [CW-1:0] ca;
   logic signed [CW-1:0] cb;
   logic signed [CW-1:0] ha;
   logic signed [CW-1:0] hb;
   logic signed [CW-1:0] lo_a;
   logic signed [CW-1:0] hi_a;
   logic signed [CW-1:0] lo_b;
   logic signed [CW-1:0] hi_b;
   logic signed [CW-1:0] hi_min;
   logic signed [CW-1:0] lo_max;

   // extend everything to the edge width
   assign ca = {{(CW-aabbcr_pkg::CTR_W){first_center[aabbcr_pkg::CTR_W-1]}}, first_center};
   assign cb = {{(CW-aabbcr_pkg::POS_W){second_center[aabbcr_pkg::POS_W-1]}}, second_center};
   assign ha = {{(CW-aabbcr_pkg::HALF_W){1'b0}}, first_half};
   assign hb = {{(CW-aabbcr_pkg::HALF_W){1'b0}}, second_half};

   // box edges
   assign lo_a = ca - ha;
   assign hi_a = ca + ha;
   assign lo_b = cb - hb;
   assign hi_b = cb + hb;

   // strict overlap and extent of the shared interval
   assign hi_min = (hi_a < hi_b) ? hi_a : hi_b;
   assign lo_max = (lo_a > lo_b) ? lo_a : lo_b;

   assign result.overlap = (lo_a < hi_b) && (hi_a > lo_b);
   assign result.extent  = hi_min - lo_max;

endmodule

// ===== sv/aabb_collision_resolver_unit.sv =====
// Overlap test and push-out for one pair of axis-aligned boxes. A request beat
// carries both boxes; if their layer masks share a bit and they overlap
// strictly, the first box is pushed out in repeated steps, at most MAX_STEPS,
// and one response beat reports the total shift, the cleared axes, the step
// count and whether the boxes still overlap. A single axis unit measures x and
// y in turn: after the request beat is accepted, the states EVAL_X, EVAL_Y and
// DECIDE run once for the initial test and again for every step, and FINISH
// loads the response once the output register is free.
// The block takes one item at a time; a finished response waits in an output
// register while the next request is accepted and worked on.
module aabb_collision_resolver_unit #(
   parameter int MAX_STEPS = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [aabbcr_pkg::POS_W-1:0]  req_first_center_x,
   input  logic signed [aabbcr_pkg::POS_W-1:0]  req_first_center_y,
   input  logic        [aabbcr_pkg::HALF_W-1:0] req_first_half_width,
   input  logic        [aabbcr_pkg::HALF_W-1:0] req_first_half_height,
   input  logic signed [aabbcr_pkg::VEL_W-1:0]  req_first_velocity_x,
   input  logic signed [aabbcr_pkg::VEL_W-1:0]  req_first_velocity_y,
   input  logic signed [aabbcr_pkg::POS_W-1:0]  req_second_center_x,
   input  logic signed [aabbcr_pkg::POS_W-1:0]  req_second_center_y,
   input  logic        [aabbcr_pkg::HALF_W-1:0] req_second_half_width,
   input  logic        [aabbcr_pkg::HALF_W-1:0] req_second_half_height,
   input  logic        [aabbcr_pkg::LAYER_W-1:0] req_first_layers,
   input  logic        [aabbcr_pkg::LAYER_W-1:0] req_second_layers,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic signed [aabbcr_pkg::SHIFT_W-1:0] rsp_shift_x,
   output logic signed [aabbcr_pkg::SHIFT_W-1:0] rsp_shift_y,
   output logic                                 rsp_clear_motion_x,
   output logic                                 rsp_clear_motion_y,
   output logic                                 rsp_still_overlapping,
   output logic        [aabbcr_pkg::STEP_W-1:0] rsp_steps_used
);

   localparam int PW = aabbcr_pkg::POS_W;
   localparam int HW = aabbcr_pkg::HALF_W;
   localparam int SW = aabbcr_pkg::SHIFT_W;
   localparam int CW = aabbcr_pkg::CTR_W;
   localparam int OW = aabbcr_pkg::COORD_W;
   localparam int UW = aabbcr_pkg::SUM_W;
   localparam int NW = aabbcr_pkg::STEP_W;
   localparam int VEL_MSB = aabbcr_pkg::VEL_W - 1;
   localparam logic [NW-1:0] STEP_LIMIT = NW'(MAX_STEPS);

   // clamp a grown shift back to the shift range
   function automatic logic signed [SW-1:0] sat_shift(input logic signed [UW-1:0] v);
      logic signed [SW-1:0] r;
      if (v[UW-1:SW-1] == '0 || v[UW-1:SW-1] == '1) begin
         r = v[SW-1:0];
      end else if (v[UW-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   aabbcr_pkg::state_type state_ff, state_in;

   // item registers
   logic signed [PW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic        [HW-1:0] aw_ff, ah_ff, bw_ff, bh_ff;
   logic                 layer_ff;
   logic                 vxn_ff, vxn_in, vxp_ff, vxp_in;
   logic                 vyn_ff, vyn_in, vyp_ff, vyp_in;

   // working registers
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                 clx_ff, clx_in, cly_ff, cly_in;
   logic                 hit_ff, hit_in, still_ff, still_in;
   logic        [NW-1:0] steps_ff, steps_in;
   logic signed [OW-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic                 ovx_ff, ovx_in, ovy_ff, ovy_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic signed [SW-1:0] rsp_sx_ff, rsp_sy_ff;
   logic                 rsp_clx_ff, rsp_cly_ff, rsp_still_ff;
   logic        [NW-1:0] rsp_steps_ff;
   logic                 load_rsp;

   // shared axis unit operands
   logic signed [CW-1:0] unit_ca;
   logic        [HW-1:0] unit_ha;
   logic signed [PW-1:0] unit_cb;
   logic        [HW-1:0] unit_hb;
   aabbcr_pkg::axis_result_type unit_res;

   // step arithmetic
   logic                 x_take, y_take, do_step, accept;
   logic signed [UW-1:0] sx_ext, sy_ext, ox_ext, oy_ext, sx_sum, sy_sum;

   assign accept = req_valid && req_ready;

   // operand select for the axis unit
   always_comb begin
      if (state_ff == aabbcr_pkg::ST_EVAL_Y) begin
         unit_ca = {{2{ay_ff[PW-1]}}, ay_ff} + {sy_ff[SW-1], sy_ff};
         unit_ha = ah_ff;
         unit_cb = by_ff;
         unit_hb = bh_ff;
      end else begin
         unit_ca = {{2{ax_ff[PW-1]}}, ax_ff} + {sx_ff[SW-1], sx_ff};
         unit_ha = aw_ff;
         unit_cb = bx_ff;
         unit_hb = bw_ff;
      end
   end

   aabbcr_axis_unit u_axis (
      .first_center  (unit_ca),
      .first_half    (unit_ha),
      .second_center (unit_cb),
      .second_half   (unit_hb),
      .result        (unit_res)
   );

   // push against the velocity sign
   assign sx_ext = {{(UW-SW){sx_ff[SW-1]}}, sx_ff};
   assign sy_ext = {{(UW-SW){sy_ff[SW-1]}}, sy_ff};
   assign ox_ext = {{(UW-OW){ox_ff[OW-1]}}, ox_ff};
   assign oy_ext = {{(UW-OW){oy_ff[OW-1]}}, oy_ff};
   assign sx_sum = vxp_ff ? (sx_ext - ox_ext) : (vxn_ff ? (sx_ext + ox_ext) : sx_ext);
   assign sy_sum = vyp_ff ? (sy_ext - oy_ext) : (vyn_ff ? (sy_ext + oy_ext) : sy_ext);

   // x wins only when positive and strictly smaller, ties go to y
   assign x_take = !ox_ff[OW-1] && (ox_ff != '0) && (ox_ff < oy_ff);
   assign y_take = !x_take && !oy_ff[OW-1] && (oy_ff != '0);

   // first pass decides the hit, later passes the loop condition
   assign do_step = hit_ff ? (ovx_ff && ovy_ff && (steps_ff < STEP_LIMIT))
                           : (layer_ff && ovx_ff && ovy_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vxn_in       = vxn_ff;
      vxp_in       = vxp_ff;
      vyn_in       = vyn_ff;
      vyp_in       = vyp_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      clx_in       = clx_ff;
      cly_in       = cly_ff;
      hit_in       = hit_ff;
      still_in     = still_ff;
      steps_in     = steps_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      ovx_in       = ovx_ff;
      ovy_in       = ovy_ff;
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         aabbcr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               vxn_in   = req_first_velocity_x[VEL_MSB];
               vxp_in   = !req_first_velocity_x[VEL_MSB] && (req_first_velocity_x != '0);
               vyn_in   = req_first_velocity_y[VEL_MSB];
               vyp_in   = !req_first_velocity_y[VEL_MSB] && (req_first_velocity_y != '0);
               sx_in    = '0;
               sy_in    = '0;
               clx_in   = 1'b0;
               cly_in   = 1'b0;
               hit_in   = 1'b0;
               still_in = 1'b0;
               steps_in = '0;
               state_in = aabbcr_pkg::ST_EVAL_X;
            end
         end
         aabbcr_pkg::ST_EVAL_X: begin
            ovx_in   = unit_res.overlap;
            ox_in    = unit_res.extent;
            state_in = aabbcr_pkg::ST_EVAL_Y;
         end
         aabbcr_pkg::ST_EVAL_Y: begin
            ovy_in   = unit_res.overlap;
            oy_in    = unit_res.extent;
            state_in = aabbcr_pkg::ST_DECIDE;
         end
         aabbcr_pkg::ST_DECIDE: begin
            if (do_step) begin
               hit_in   = 1'b1;
               steps_in = steps_ff + NW'(1);
               if (x_take) begin
                  sx_in  = sat_shift(sx_sum);
                  vxn_in = 1'b0;
                  vxp_in = 1'b0;
                  clx_in = 1'b1;
               end else if (y_take) begin
                  sy_in  = sat_shift(sy_sum);
                  vyn_in = 1'b0;
                  vyp_in = 1'b0;
                  cly_in = 1'b1;
               end
               state_in = aabbcr_pkg::ST_EVAL_X;
            end else begin
               still_in = hit_ff && ovx_ff && ovy_ff;
               state_in = aabbcr_pkg::ST_FINISH;
            end
         end
         aabbcr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = aabbcr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aabbcr_pkg::ST_IDLE;
         end
      endcase
   end

   // output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aabbcr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff    <= req_first_center_x;
         ay_ff    <= req_first_center_y;
         aw_ff    <= req_first_half_width;
         ah_ff    <= req_first_half_height;
         bx_ff    <= req_second_center_x;
         by_ff    <= req_second_center_y;
         bw_ff    <= req_second_half_width;
         bh_ff    <= req_second_half_height;
         layer_ff <= (req_first_layers & req_second_layers) != '0;
      end
   end

   // working state
   always_ff @(posedge clock) begin
      vxn_ff   <= vxn_in;
      vxp_ff   <= vxp_in;
      vyn_ff   <= vyn_in;
      vyp_ff   <= vyp_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      clx_ff   <= clx_in;
      cly_ff   <= cly_in;
      hit_ff   <= hit_in;
      still_ff <= still_in;
      steps_ff <= steps_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      ovx_ff   <= ovx_in;
      ovy_ff   <= ovy_in;
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hit_ff   <= hit_ff;
         rsp_sx_ff    <= sx_ff;
         rsp_sy_ff    <= sy_ff;
         rsp_clx_ff   <= clx_ff;
         rsp_cly_ff   <= cly_ff;
         rsp_still_ff <= still_ff;
         rsp_steps_ff <= steps_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_shift_x           = rsp_sx_ff;
   assign rsp_shift_y           = rsp_sy_ff;
   assign rsp_clear_motion_x    = rsp_clx_ff;
   assign rsp_clear_motion_y    = rsp_cly_ff;
   assign rsp_still_overlapping = rsp_still_ff;
   assign rsp_steps_used        = rsp_steps_ff;

endmodule
